>>> hdl/md5sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and step functions of the streaming MD5 hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam int LENGTH_COUNT_BITS_DEF = 64;
    localparam int BLOCK_WORDS           = 16;
    localparam int BLOCK_ADDR_W          = $clog2(BLOCK_WORDS);
    localparam int STEPS                 = 64;
    localparam int STEP_W                = $clog2(STEPS);

    localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
    localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
    localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
    localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK     = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_HEAD,
        ST_PAD_FILL,
        ST_PRIME,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef logic [31:0] word_t;

    function automatic word_t step_const(input logic [STEP_W-1:0] k);
        word_t c;
        unique case (k)
            6'd0:  c = 32'hd76aa478;  6'd1:  c = 32'he8c7b756;
            6'd2:  c = 32'h242070db;  6'd3:  c = 32'hc1bdceee;
            6'd4:  c = 32'hf57c0faf;  6'd5:  c = 32'h4787c62a;
            6'd6:  c = 32'ha8304613;  6'd7:  c = 32'hfd469501;
            6'd8:  c = 32'h698098d8;  6'd9:  c = 32'h8b44f7af;
            6'd10: c = 32'hffff5bb1;  6'd11: c = 32'h895cd7be;
            6'd12: c = 32'h6b901122;  6'd13: c = 32'hfd987193;
            6'd14: c = 32'ha679438e;  6'd15: c = 32'h49b40821;
            6'd16: c = 32'hf61e2562;  6'd17: c = 32'hc040b340;
            6'd18: c = 32'h265e5a51;  6'd19: c = 32'he9b6c7aa;
            6'd20: c = 32'hd62f105d;  6'd21: c = 32'h02441453;
            6'd22: c = 32'hd8a1e681;  6'd23: c = 32'he7d3fbc8;
            6'd24: c = 32'h21e1cde6;  6'd25: c = 32'hc33707d6;
            6'd26: c = 32'hf4d50d87;  6'd27: c = 32'h455a14ed;
            6'd28: c = 32'ha9e3e905;  6'd29: c = 32'hfcefa3f8;
            6'd30: c = 32'h676f02d9;  6'd31: c = 32'h8d2a4c8a;
            6'd32: c = 32'hfffa3942;  6'd33: c = 32'h8771f681;
            6'd34: c = 32'h6d9d6122;  6'd35: c = 32'hfde5380c;
            6'd36: c = 32'ha4beea44;  6'd37: c = 32'h4bdecfa9;
            6'd38: c = 32'hf6bb4b60;  6'd39: c = 32'hbebfbc70;
            6'd40: c = 32'h289b7ec6;  6'd41: c = 32'heaa127fa;
            6'd42: c = 32'hd4ef3085;  6'd43: c = 32'h04881d05;
            6'd44: c = 32'hd9d4d039;  6'd45: c = 32'he6db99e5;
            6'd46: c = 32'h1fa27cf8;  6'd47: c = 32'hc4ac5665;
            6'd48: c = 32'hf4292244;  6'd49: c = 32'h432aff97;
            6'd50: c = 32'hab9423a7;  6'd51: c = 32'hfc93a039;
            6'd52: c = 32'h655b59c3;  6'd53: c = 32'h8f0ccc92;
            6'd54: c = 32'hffeff47d;  6'd55: c = 32'h85845dd1;
            6'd56: c = 32'h6fa87e4f;  6'd57: c = 32'hfe2ce6e0;
            6'd58: c = 32'ha3014314;  6'd59: c = 32'h4e0811a1;
            6'd60: c = 32'hf7537e82;  6'd61: c = 32'hbd3af235;
            6'd62: c = 32'h2ad7d2bb;  6'd63: c = 32'heb86d391;
            default: c = 32'h0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [STEP_W-1:0] k);
        logic [4:0] s;
        unique case ({k[5:4], k[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word taken by step k
    function automatic logic [BLOCK_ADDR_W-1:0] msg_index(input logic [STEP_W-1:0] k);
        logic [BLOCK_ADDR_W-1:0] lo;
        logic [BLOCK_ADDR_W-1:0] g;
        lo = k[BLOCK_ADDR_W-1:0];
        unique case (k[5:4])
            2'd0: g = lo;
            2'd1: g = BLOCK_ADDR_W'(5 * lo + 1);
            2'd2: g = BLOCK_ADDR_W'(3 * lo + 5);
            2'd3: g = BLOCK_ADDR_W'(7 * lo);
            default: g = lo;
        endcase
        return g;
    endfunction

    // bytes below pos from the partial word, pos gets the new byte, zeros above
    function automatic word_t merge_word(input logic [23:0] acc, input logic [7:0] bt,
                                         input logic [1:0] pos);
        word_t w;
        unique case (pos)
            2'd0: w = {24'h0, bt};
            2'd1: w = {16'h0, bt, acc[7:0]};
            2'd2: w = {8'h0, bt, acc[15:0]};
            2'd3: w = {bt, acc[23:0]};
            default: w = 32'h0;
        endcase
        return w;
    endfunction

    function automatic word_t byte_swap(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

>>> hdl/md5sh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5sh_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/md5sh_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_round
// One MD5 step: mixing function, constant add, rotate and word shuffle.
// ----------------------------------------------------------------------------
module md5sh_round
    import md5sh_pkg::*;
(
    input  logic [STEP_W-1:0] step,
    input  word_t             a_in,
    input  word_t             b_in,
    input  word_t             c_in,
    input  word_t             d_in,
    input  word_t             msg,
    output word_t             a_out,
    output word_t             b_out,
    output word_t             c_out,
    output word_t             d_out
);

    word_t       mix;
    word_t       sum;
    logic [63:0] rot_wide;

    always_comb
    begin
        unique case (step[5:4])
            2'd0: mix = (b_in & c_in) | (~b_in & d_in);
            2'd1: mix = (b_in & d_in) | (c_in & ~d_in);
            2'd2: mix = b_in ^ c_in ^ d_in;
            2'd3: mix = c_in ^ (b_in | ~d_in);
            default: mix = 32'h0;
        endcase
    end

    assign sum      = a_in + mix + msg + step_const(step);
    assign rot_wide = {sum, sum} << rot_amount(step);

    assign a_out = d_in;
    assign b_out = b_in + rot_wide[63:32];
    assign c_out = b_in;
    assign d_out = c_in;

endmodule

>>> hdl/md5_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher
// Byte-stream MD5: block words in a RAM, one step per cycle, four digest words.
// ----------------------------------------------------------------------------
// a byte without block completion leaves the hasher ready for the next byte;
// each 64-byte block then costs a read prime, 64 steps bound by the single
// block RAM read port and a chaining add; the last item adds the padding
// writes (up to 18), one or two compressions and four output transactions
// reset (async, active low) loads the initial chaining words, clears the
// bit count and returns to idle; block RAM contents are not cleared
module md5_stream_hasher
    import md5sh_pkg::*;
#(
    parameter int LENGTH_COUNT_BITS = LENGTH_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_last
    input  logic        s_axis_tuser,   // [0] no_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [33:32] word_index, zero fill
    output logic        m_axis_tlast    // last_word
);

    state_t state_reg, state_next;
    word_t  chain_reg [4];
    word_t  chain_next [4];
    word_t  round_reg [4];
    word_t  round_next [4];
    logic [LENGTH_COUNT_BITS-1:0] count_reg, count_next;
    logic [23:0]             acc_reg, acc_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [BLOCK_ADDR_W-1:0] fill_reg, fill_next;
    logic [1:0]              idx_reg, idx_next;
    logic pad_pending_reg, pad_pending_next;
    logic pad_active_reg, pad_active_next;
    logic pad_two_reg, pad_two_next;

    logic                    ram_we;
    logic [BLOCK_ADDR_W-1:0] ram_waddr;
    word_t                   ram_wdata;
    logic [BLOCK_ADDR_W-1:0] ram_raddr;
    word_t                   ram_rdata;

    word_t       step_a, step_b, step_c, step_d;
    logic [63:0] len_ext;
    logic [5:0]  pos;
    logic        in_fire;
    logic        out_fire;

    md5sh_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5sh_round u_round (
        .step  (step_reg),
        .a_in  (round_reg[0]),
        .b_in  (round_reg[1]),
        .c_in  (round_reg[2]),
        .d_in  (round_reg[3]),
        .msg   (ram_rdata),
        .a_out (step_a),
        .b_out (step_b),
        .c_out (step_c),
        .d_out (step_d)
    );

    assign len_ext  = 64'(count_reg);
    assign pos      = count_reg[8:3];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {6'h0, idx_reg, byte_swap(chain_reg[idx_reg])};
    assign m_axis_tlast  = (idx_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chain_reg[0]    <= CHAIN_INIT_A;
            chain_reg[1]    <= CHAIN_INIT_B;
            chain_reg[2]    <= CHAIN_INIT_C;
            chain_reg[3]    <= CHAIN_INIT_D;
            round_reg[0]    <= '0;
            round_reg[1]    <= '0;
            round_reg[2]    <= '0;
            round_reg[3]    <= '0;
            count_reg       <= '0;
            step_reg        <= '0;
            fill_reg        <= '0;
            idx_reg         <= '0;
            pad_pending_reg <= 1'b0;
            pad_active_reg  <= 1'b0;
            pad_two_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chain_reg       <= chain_next;
            round_reg       <= round_next;
            count_reg       <= count_next;
            step_reg        <= step_next;
            fill_reg        <= fill_next;
            idx_reg         <= idx_next;
            pad_pending_reg <= pad_pending_next;
            pad_active_reg  <= pad_active_next;
            pad_two_reg     <= pad_two_next;
        end
    end

    // partial word is payload only
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        chain_next       = chain_reg;
        round_next       = round_reg;
        count_next       = count_reg;
        acc_next         = acc_reg;
        step_next        = step_reg;
        fill_next        = fill_reg;
        idx_next         = idx_reg;
        pad_pending_next = pad_pending_reg;
        pad_active_next  = pad_active_reg;
        pad_two_next     = pad_two_reg;
        ram_we           = 1'b0;
        ram_waddr        = pos[5:2];
        ram_wdata        = merge_word(acc_reg, s_axis_tdata, pos[1:0]);
        ram_raddr        = msg_index(step_reg + 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pad_pending_next = s_axis_tlast;
                    if (!s_axis_tuser)
                    begin
                        ram_we     = 1'b1;
                        acc_next   = ram_wdata[23:0];
                        count_next = count_reg + LENGTH_COUNT_BITS'(8);
                        if (pos == 6'd63)
                        begin
                            state_next = ST_PRIME;
                        end
                        else if (s_axis_tlast)
                        begin
                            state_next = ST_PAD_HEAD;
                        end
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD_HEAD;
                    end
                end
            end

            ST_PAD_HEAD:
            begin
                ram_we           = 1'b1;
                ram_wdata        = merge_word(acc_reg, PAD_MARK, pos[1:0]);
                pad_active_next  = 1'b1;
                pad_pending_next = 1'b0;
                // no room for the length in this block
                pad_two_next     = (pos[5:3] == 3'd7);
                fill_next        = pos[5:2] + 1'b1;
                state_next       = (pos[5:2] == 4'd15) ? ST_PRIME : ST_PAD_FILL;
            end

            ST_PAD_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                if (!pad_two_reg && fill_reg == 4'd14)
                begin
                    ram_wdata = len_ext[31:0];
                end
                else if (!pad_two_reg && fill_reg == 4'd15)
                begin
                    ram_wdata = len_ext[63:32];
                end
                else
                begin
                    ram_wdata = '0;
                end
                fill_next = fill_reg + 1'b1;
                if (fill_reg == 4'd15)
                begin
                    state_next = ST_PRIME;
                end
            end

            ST_PRIME:
            begin
                ram_raddr  = msg_index('0);
                round_next = chain_reg;
                step_next  = '0;
                state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                round_next[0] = step_a;
                round_next[1] = step_b;
                round_next[2] = step_c;
                round_next[3] = step_d;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + round_reg[i];
                end
                if (pad_active_reg)
                begin
                    if (pad_two_reg)
                    begin
                        pad_two_next = 1'b0;
                        fill_next    = '0;
                        state_next   = ST_PAD_FILL;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    state_next = pad_pending_reg ? ST_PAD_HEAD : ST_IDLE;
                end
            end

            ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        chain_next[0]   = CHAIN_INIT_A;
                        chain_next[1]   = CHAIN_INIT_B;
                        chain_next[2]   = CHAIN_INIT_C;
                        chain_next[3]   = CHAIN_INIT_D;
                        count_next      = '0;
                        pad_active_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a fold always follows the last of the 64 steps
    a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |->
            ($past(state_reg) == ST_ROUND && $past(step_reg) == STEP_W'(STEPS - 1)))
        else $error("fold entered without completing the steps");

    // no block writes while a compression reads the RAM
    a_no_write_in_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRIME || state_reg == ST_ROUND || state_reg == ST_FOLD)
            |-> !ram_we)
        else $error("block RAM written during compression");

    // digest delivery restarts the chaining state
    a_restart_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_axis_tlast) |=>
            (count_reg == '0 && chain_reg[0] == CHAIN_INIT_A && state_reg == ST_IDLE))
        else $error("chaining state not restarted after digest");

    // results only come out of a padded message
    a_out_needs_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pad_active_reg && !pad_two_reg))
        else $error("digest presented before padding finished");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher testbench
// Streams byte messages into the hasher with random gaps on both sides and
// checks every digest transaction against a behavioural MD5 predictor kept
// inside the bench; covers empty and byte-less endings, padding that spills
// into an extra block, multi-block messages and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

    import md5sh_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 380;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // is_last
    logic        s_axis_tuser = 1'b0;    // [0] no_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [31:0] digest_word, [33:32] word_index, zero fill
    logic        m_axis_tlast;           // last_word

    md5_stream_hasher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // sine-derived step additives and per-step rotations
    logic [31:0] md5_k [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int md5_r [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // predictor state
    logic [31:0]  hash_chain [0:3];
    logic [31:0]  msg_block  [0:15];
    logic [63:0]  msg_bits;
    digest_beat_t digest_queue [$];

    int fail_count    = 0;
    int items_sent    = 0;
    int rx_hold_cycles = 0;
    bit tx_burst      = 1'b0;
    bit rx_burst      = 1'b0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic void restart_chain();
        hash_chain[0] = CHAIN_INIT_A;
        hash_chain[1] = CHAIN_INIT_B;
        hash_chain[2] = CHAIN_INIT_C;
        hash_chain[3] = CHAIN_INIT_D;
        msg_bits      = 64'd0;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void hash_block();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        for (int k = 0; k < 64; k++)
        begin
            case (k / 16)
                0:       begin f = (b & c) | (~b & d); g = k;                end
                1:       begin f = (b & d) | (c & ~d); g = (5 * k + 1) % 16; end
                2:       begin f = b ^ c ^ d;          g = (3 * k + 5) % 16; end
                default: begin f = c ^ (b | ~d);       g = (7 * k) % 16;     end
            endcase
            t = a + f + msg_block[g] + md5_k[k];
            t = b + rotl32(t, md5_r[(k / 16) * 4 + k % 4]);
            a = d;
            d = c;
            c = b;
            b = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
    endfunction

    function automatic void put_msg_byte(input int pos, input logic [7:0] b);
        msg_block[pos / 4][8 * (pos % 4) +: 8] = b;
    endfunction

    // advances the predictor by one accepted transaction
    function automatic void predict_digest(input logic [7:0] data, input logic last,
                                           input logic nobyte);
        int pos;
        digest_beat_t beat;
        if (!nobyte)
        begin
            pos = int'(msg_bits[8:3]);
            put_msg_byte(pos, data);
            msg_bits += 64'd8;
            if (pos == 63)
                hash_block();
        end
        if (last)
        begin
            pos = int'(msg_bits[8:3]);
            put_msg_byte(pos, PAD_MARK);
            for (int k = pos + 1; k < 64; k++)
                put_msg_byte(k, 8'h00);
            // no room left for the length, so one extra block
            if (pos >= 56)
            begin
                hash_block();
                for (int k = 0; k < 16; k++)
                    msg_block[k] = 32'h0;
            end
            msg_block[14] = msg_bits[31:0];
            msg_block[15] = msg_bits[63:32];
            hash_block();
            for (int k = 0; k < 4; k++)
            begin
                beat.digest_word = {<<8{hash_chain[k]}};
                beat.word_index  = 2'(k);
                beat.last_word   = (k == 3);
                digest_queue.push_back(beat);
            end
            restart_chain();
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic last, input logic nobyte);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        s_axis_tuser  <= nobyte;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        // dropped before the next falling edge; never low at a rising edge in a burst
        s_axis_tvalid <= 1'b0;
        predict_digest(data, last, nobyte);
        items_sent++;
    endtask

    // len bytes, then either the last byte carries tlast or a byte-less item ends it
    task automatic send_message(input int len, input bit byteless_end, input bit noisy);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(8'($urandom_range(0, 255)), (i == len - 1) && !byteless_end, 1'b0);
        end
        if (len == 0 || byteless_end)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        while (digest_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_message();
        send_item(8'hff, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_ignored_item();
        // byte-less item without tlast must leave the message untouched
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'h61, 1'b0, 1'b0);
        send_item(8'h62, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        tx_burst       = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);
        tx_burst = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_messages();
        int msg_count;
        int sel;
        int len;
        msg_count = 0;
        while (items_sent < ITEM_TARGET || msg_count < 3)
        begin
            if ($urandom_range(0, 5) == 0)
                tx_burst = ~tx_burst;
            if ($urandom_range(0, 5) == 0)
                rx_burst = ~rx_burst;
            sel = $urandom_range(0, 9);
            if (sel <= 5)
                len = $urandom_range(0, 15);
            else if (sel <= 8)
                len = $urandom_range(54, 65);
            else
                len = $urandom_range(118, 129);
            send_message(len, 1'($urandom_range(0, 1)), 1'b1);
            msg_count++;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        wait_drained();
    endtask

    // digest sink: random ready gaps, one check per transaction
    initial
    begin : digest_sink
        int stall;
        digest_beat_t exp_beat;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else if (rx_burst)
                stall = 0;
            else
                stall = $urandom_range(0, 9);
            repeat (stall) @(negedge clk);
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            m_axis_tready <= 1'b0;
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest transaction %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_beat = digest_queue.pop_front();
                if (m_axis_tdata[31:0] !== exp_beat.digest_word)
                begin
                    $error("digest_word exp %h act %h", exp_beat.digest_word,
                           m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[33:32] !== exp_beat.word_index)
                begin
                    $error("word_index exp %0d act %0d", exp_beat.word_index,
                           m_axis_tdata[33:32]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_beat.last_word)
                begin
                    $error("last_word exp %b act %b", exp_beat.last_word, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[39:34] !== 6'h0)
                begin
                    $error("zero_fill exp %h act %h", 6'h0, m_axis_tdata[39:34]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin : stall_watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        restart_chain();
        for (int k = 0; k < 16; k++)
            msg_block[k] = 32'h0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_ignored_item();
        test_byte_extremes();
        test_output_backpressure();
        test_random_messages();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/md5sh_pkg.sv
hdl/md5sh_ram.sv
hdl/md5sh_round.sv
hdl/md5_stream_hasher.sv
dv/testbench.sv
